FILE: rtl/core/mkdr_pkg.sv
// ----------------------------------------------------------------------------
// mkdr_pkg
// Shared types and constants for the keypad debounce / auto-repeat block.
// ----------------------------------------------------------------------------
package mkdr_pkg;

  localparam int unsigned LINE_W  = 4;
  localparam int unsigned PAT_W   = 2 * LINE_W;
  localparam int unsigned KEY_W   = 4;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned CFG_A_W = 2;
  localparam int unsigned CFG_D_W = 8;

  typedef logic [CFG_A_W-1:0] cfg_addr_t;
  typedef logic [PAT_W-1:0]   pattern_t;
  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [KEY_W-1:0]   key_t;

  // register map
  localparam cfg_addr_t REG_REPEAT_DELAY  = 2'd0;
  localparam cfg_addr_t REG_REPEAT_RELOAD = 2'd1;

  localparam count_t REPEAT_DELAY_RST  = 8'd20;
  localparam count_t REPEAT_RELOAD_RST = 8'd18;

  // one-hot nibble to position+1; zero for no line or several lines
  function automatic logic [2:0] onehot_pos(input logic [LINE_W-1:0] nib);
    logic [2:0] pos;
    unique case (nib)
      4'b0001: pos = 3'd1;
      4'b0010: pos = 3'd2;
      4'b0100: pos = 3'd3;
      4'b1000: pos = 3'd4;
      default: pos = 3'd0;
    endcase
    return pos;
  endfunction

endpackage

FILE: rtl/core/matrix_keypad_debounce_repeat.sv
// ----------------------------------------------------------------------------
// matrix_keypad_debounce_repeat
// 4x4 keypad sample debouncer with press detect and auto-repeat key decode.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in_valid/in_ready    | high_lines, low_lines
//  out     | out_valid/out_ready  | key_valid, key_index, stable_pattern
//
//  One word per clock while out_ready drains the output register: the
//  debounce and hold-count update is a single level of compare/increment logic
//  between the state registers and the output register.
//  in_ready drops only while the output register holds a word that is not
//  being taken this cycle; cfg_ready is always high.
//  Synchronous reset clears the debounce state, hold counter and out_valid and
//  restores repeat_delay = 20, repeat_reload = 18.
//
module matrix_keypad_debounce_repeat (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mkdr_pkg::CFG_A_W-1:0]        cfg_index,
  input  logic [mkdr_pkg::CFG_D_W-1:0]        cfg_data,
  // line samples
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mkdr_pkg::LINE_W-1:0]         high_lines,
  input  logic [mkdr_pkg::LINE_W-1:0]         low_lines,
  // key events
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                key_valid,
  output logic [mkdr_pkg::KEY_W-1:0]          key_index,
  output logic [mkdr_pkg::PAT_W-1:0]          stable_pattern
);

  // config registers
  mkdr_pkg::count_t repeat_delay;
  mkdr_pkg::count_t repeat_reload;

  // debounce state
  mkdr_pkg::pattern_t previous_sample;
  mkdr_pkg::pattern_t stable_keys;
  mkdr_pkg::count_t   hold_count;

  mkdr_pkg::pattern_t stable_keys_next;
  mkdr_pkg::count_t   hold_count_next;
  mkdr_pkg::count_t   hold_inc;
  mkdr_pkg::pattern_t sample;
  logic               fire;
  logic [2:0]         row_pos;
  logic [2:0]         col_pos;
  logic               decode_ok;
  logic               key_valid_next;
  mkdr_pkg::key_t     key_index_next;
  logic               in_fire;

  assign cfg_ready = 1'b1;
  // output register frees up when empty or being drained
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // lines are active low; invert so a 1 marks an active line
  assign sample   = ~{high_lines, low_lines};
  assign hold_inc = hold_count + 8'd1;

  always_comb begin
    stable_keys_next = stable_keys;
    hold_count_next  = hold_count;
    fire             = 1'b0;
    // only a pattern seen on two consecutive ticks is taken as stable
    if (sample == previous_sample) begin
      stable_keys_next = sample;
      if (sample == '0) begin
        hold_count_next = '0;                 // released: clear hold
      end else if (stable_keys == '0) begin
        fire = 1'b1;                          // fresh press
      end else if (stable_keys == sample) begin
        // same key still held: count toward repeat
        if (hold_inc >= repeat_delay) begin
          hold_count_next = repeat_reload;
          fire            = 1'b1;
        end else begin
          hold_count_next = hold_inc;
        end
      end
      // a change between two nonzero patterns: no event, hold kept
    end
  end

  // key decode: exactly one active line per nibble
  assign row_pos   = mkdr_pkg::onehot_pos(stable_keys_next[7:4]);
  assign col_pos   = mkdr_pkg::onehot_pos(stable_keys_next[3:0]);
  assign decode_ok = (row_pos != 3'd0) && (col_pos != 3'd0);

  always_comb begin
    key_valid_next = fire && decode_ok;
    key_index_next = '0;
    if (key_valid_next) begin
      key_index_next = {2'(row_pos - 3'd1), 2'(col_pos - 3'd1)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay    <= mkdr_pkg::REPEAT_DELAY_RST;
      repeat_reload   <= mkdr_pkg::REPEAT_RELOAD_RST;
      previous_sample <= '0;
      stable_keys     <= '0;
      hold_count      <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mkdr_pkg::REG_REPEAT_DELAY:  repeat_delay  <= cfg_data;
          mkdr_pkg::REG_REPEAT_RELOAD: repeat_reload <= cfg_data;
          default: ;                          // unmapped index ignored
        endcase
      end
      if (in_fire) begin
        previous_sample <= sample;
        stable_keys     <= stable_keys_next;
        hold_count      <= hold_count_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid       <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_valid      <= key_valid_next;
      key_index      <= key_index_next;
      stable_pattern <= stable_keys_next;
    end
  end

endmodule

FILE: rtl/core/mkdr_checker.sv
// ----------------------------------------------------------------------------
// mkdr_checker
// Port-level checks for the keypad debounce block, bound to the top level.
// ----------------------------------------------------------------------------
module mkdr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         key_valid,
  input logic [mkdr_pkg::KEY_W-1:0]   key_index,
  input logic [mkdr_pkg::PAT_W-1:0]   stable_pattern
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(key_valid) &&
      $stable(key_index) && $stable(stable_pattern))
    else $error("stalled output word changed");

  // an empty output stage never blocks input
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  // no key means index zero
  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !key_valid |-> key_index == '0)
    else $error("key_index nonzero without key");

  // a key only from one line per nibble, matching the index
  a_key_decode: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_valid |-> $onehot(stable_pattern[7:4]) &&
      $onehot(stable_pattern[3:0]) && stable_pattern[3'd4 + key_index[3:2]] &&
      stable_pattern[key_index[1:0]])
    else $error("key index inconsistent with stable pattern");

  // an accepted sample always yields a word next cycle
  a_accept_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted sample produced no output word");

endmodule

bind matrix_keypad_debounce_repeat mkdr_checker u_mkdr_checker (.*);

FILE: verif/matrix_keypad_debounce_repeat_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_keypad_debounce_repeat_test
// Self-checking bench for the keypad debounce / auto-repeat block. Line
// samples go in as held key runs, releases, multi-line patterns and contact
// bounce. A per-sample tracker of the debounce and hold-count state predicts
// every output word. Repeat delay and reload are swept between phases,
// including zero, full-scale and reload-above-delay settings.
// ----------------------------------------------------------------------------
module matrix_keypad_debounce_repeat_test;

  // indexes with no register behind them; writes there must be dropped
  localparam mkdr_pkg::cfg_addr_t REG_SPARE_LO = 2'd2;
  localparam mkdr_pkg::cfg_addr_t REG_SPARE_HI = 2'd3;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_OFF_CYCLES = 60;

  // opening sequence as {high_lines, low_lines}, both active low:
  // idle, key 0 press and hold, one bounced sample, key 0 again, move to
  // key 15 without release, release, all lines, no row line, two row lines
  localparam logic [7:0] DIRECTED_SEQ [24] = '{
    8'hFF, 8'hFF, 8'hEE, 8'hEE, 8'hEE, 8'hFE, 8'hEE, 8'hEE,
    8'h77, 8'h77, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF,
    8'hF7, 8'hF7, 8'hFF, 8'hFF, 8'h3E, 8'h3E, 8'hFF, 8'hFF
  };

  typedef struct packed {
    logic               key_valid;
    mkdr_pkg::key_t     key_index;
    mkdr_pkg::pattern_t stable_pattern;
  } key_event_t;

  // --------------------------------------------------------------------------
  // Tracks the debounce state and holds the output words still owed.
  // --------------------------------------------------------------------------
  class key_event_tracker;
    mkdr_pkg::count_t   delay;
    mkdr_pkg::count_t   reload;
    mkdr_pkg::pattern_t last_sample;
    mkdr_pkg::pattern_t debounced;
    mkdr_pkg::count_t   hold;
    key_event_t         owed_words[$];
    int                 fail_count;
    int                 words;
    int                 presses;
    int                 repeats;
    int                 undecodable;

    function new();
      delay       = mkdr_pkg::REPEAT_DELAY_RST;
      reload      = mkdr_pkg::REPEAT_RELOAD_RST;
      last_sample = '0;
      debounced   = '0;
      hold        = '0;
    endfunction

    function void set_register(mkdr_pkg::cfg_addr_t idx,
                               logic [mkdr_pkg::CFG_D_W-1:0] data);
      case (idx)
        mkdr_pkg::REG_REPEAT_DELAY: begin
          delay = data;
        end
        mkdr_pkg::REG_REPEAT_RELOAD: begin
          reload = data;
        end
        default: begin
        end
      endcase
    endfunction

    // 1-based line number, 0 unless exactly one line is active
    function logic [2:0] line_number(logic [mkdr_pkg::LINE_W-1:0] nib);
      logic [2:0] num;
      num = 3'd0;
      if ($countones(nib) == 1) begin
        for (int i = 0; i < mkdr_pkg::LINE_W; i++) begin
          if (nib[i]) num = 3'(i + 1);
        end
      end
      return num;
    endfunction

    function void take_sample(logic [mkdr_pkg::LINE_W-1:0] hi,
                              logic [mkdr_pkg::LINE_W-1:0] lo);
      mkdr_pkg::pattern_t smp;
      mkdr_pkg::pattern_t was;
      logic               fire;
      logic               is_repeat;
      logic [2:0]         row;
      logic [2:0]         col;
      key_event_t         ev;
      smp       = ~{hi, lo};
      fire      = 1'b0;
      is_repeat = 1'b0;
      ev        = '0;
      if (smp == last_sample) begin
        was       = debounced;
        debounced = smp;
        if (debounced == '0) begin
          hold = '0;
        end else if (was == '0) begin
          fire = 1'b1;
        end else if (was == debounced) begin
          hold = hold + 8'd1;
          if (hold >= delay) begin
            hold      = reload;
            fire      = 1'b1;
            is_repeat = 1'b1;
          end
        end
      end
      last_sample = smp;
      if (fire) begin
        row = line_number(debounced[mkdr_pkg::PAT_W-1:mkdr_pkg::LINE_W]);
        col = line_number(debounced[mkdr_pkg::LINE_W-1:0]);
        if (row != 3'd0 && col != 3'd0) begin
          ev.key_valid = 1'b1;
          ev.key_index = mkdr_pkg::key_t'((row - 3'd1) * 4 + (col - 3'd1));
          if (is_repeat) repeats++;
          else presses++;
        end else begin
          undecodable++;
        end
      end
      ev.stable_pattern = debounced;
      owed_words.push_back(ev);
    endfunction

    function void check_word(logic kv, mkdr_pkg::key_t ki, mkdr_pkg::pattern_t sp);
      key_event_t ev;
      if (owed_words.size() == 0) begin
        $error("word with no sample behind it: key_valid %0d key_index %0d pattern %h",
               kv, ki, sp);
        fail_count++;
        return;
      end
      ev = owed_words.pop_front();
      words++;
      if (kv !== ev.key_valid) begin
        $error("key_valid: expected %0d, got %0d", ev.key_valid, kv);
        fail_count++;
      end
      if (ki !== ev.key_index) begin
        $error("key_index: expected %0d, got %0d", ev.key_index, ki);
        fail_count++;
      end
      if (sp !== ev.stable_pattern) begin
        $error("stable_pattern: expected %h, got %h", ev.stable_pattern, sp);
        fail_count++;
      end
    endfunction

    function int pending();
      return owed_words.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                          clk = 1'b0;
  logic                          rst;
  logic                          cfg_valid;
  logic                          cfg_ready;
  mkdr_pkg::cfg_addr_t           cfg_index;
  logic [mkdr_pkg::CFG_D_W-1:0]  cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic [mkdr_pkg::LINE_W-1:0]   high_lines;
  logic [mkdr_pkg::LINE_W-1:0]   low_lines;
  logic                          out_valid;
  logic                          out_ready;
  logic                          key_valid;
  mkdr_pkg::key_t                key_index;
  mkdr_pkg::pattern_t            stable_pattern;

  matrix_keypad_debounce_repeat DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .high_lines     (high_lines),
    .low_lines      (low_lines),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .key_valid      (key_valid),
    .key_index      (key_index),
    .stable_pattern (stable_pattern)
  );

  // 12 ns clock, first rising edge at 6 ns
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  key_event_tracker tracker;
  bit          gaps_on;        // sender inserts idle gaps between bursts
  bit          stall_request;  // main flow asks the receiver for a long hold-off
  int          burst_left;
  int          sent;
  int          settings;
  int unsigned cycle_count = 0;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("no progress after %0d cycles, %0d words still owed",
             CYCLE_LIMIT, tracker.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Output monitor: every word taken is checked against the oldest one owed.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      tracker.check_word(key_valid, key_index, stable_pattern);
    end
  end

  // Receiver: out_ready follows a pattern whose mode is redrawn at random
  // (always ready, mostly ready, rotating mask, mostly stalled).
  // A request from the main flow starts a long hold-off counted here, which
  // backs the block up until in_ready drops.
  initial begin : receiver
    int         hold_left;
    int         mode_left;
    int         mode;
    logic [7:0] mask;
    hold_left = 0;
    mode_left = 0;
    mode      = 0;
    mask      = 8'b1011_0110;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        hold_left     = HOLD_OFF_CYCLES;
      end
      mask = {mask[6:0], mask[7]};
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= mask[0];
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. Inputs move on the falling edge; handshakes are seen on the
  // rising edge.
  // --------------------------------------------------------------------------

  // one sample word; valid stays up until the block takes it
  task automatic push_sample(input logic [mkdr_pkg::LINE_W-1:0] hi,
                             input logic [mkdr_pkg::LINE_W-1:0] lo);
    @(negedge clk);
    in_valid   <= 1'b1;
    high_lines <= hi;
    low_lines  <= lo;
    do @(posedge clk); while (!in_ready);
    tracker.take_sample(hi, lo);
  endtask

  task automatic idle_cycles(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // sender works in bursts; with gaps on, an idle gap opens each new burst
  task automatic send_tick(input logic [mkdr_pkg::LINE_W-1:0] hi,
                           input logic [mkdr_pkg::LINE_W-1:0] lo);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        idle_cycles(gap);
      end
    end
    burst_left--;
    push_sample(hi, lo);
    sent++;
  endtask

  // stop sending and wait until every owed word has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input mkdr_pkg::cfg_addr_t idx,
                           input logic [mkdr_pkg::CFG_D_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // new delay/reload pair, plus a write to an unused index that must not stick
  task automatic reconfigure(input mkdr_pkg::count_t dly, input mkdr_pkg::count_t rld);
    mkdr_pkg::cfg_addr_t spare;
    spare = ($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO;
    wait_drained();
    cfg_write(mkdr_pkg::REG_REPEAT_DELAY, dly);
    cfg_write(spare, 8'($urandom_range(0, 255)));
    cfg_write(mkdr_pkg::REG_REPEAT_RELOAD, rld);
    settings++;
  endtask

  // active-low line samples for a single key: row on high lines, column on low
  function automatic logic [7:0] key_lines(input mkdr_pkg::key_t key);
    return {~(4'b0001 << key[3:2]), ~(4'b0001 << key[1:0])};
  endfunction

  // Runs of a held pattern: mostly single keys, some releases, some
  // arbitrary multi-line patterns. Lengths are mostly short with regular
  // long holds so repeats fire. About one tick in twelve is a bounced
  // random sample, which breaks the run's debounce.
  task automatic random_runs(input int n);
    int         stop;
    int         len;
    int         pick;
    logic [7:0] pat;
    logic [7:0] bounce;
    stop = sent + n;
    while (sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) pat = key_lines(mkdr_pkg::key_t'($urandom_range(0, 15)));
      else if (pick < 80) pat = 8'hFF;
      else pat = 8'($urandom_range(0, 255));
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 6);
      repeat (len) begin
        if ($urandom_range(0, 11) == 0) begin
          bounce = 8'($urandom_range(0, 255));
          send_tick(bounce[7:4], bounce[3:0]);
        end else begin
          send_tick(pat[7:4], pat[3:0]);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main flow
  // --------------------------------------------------------------------------
  initial begin : main_flow
    logic [7:0] long_key;
    tracker       = new();
    gaps_on       = 1'b0;
    stall_request = 1'b0;
    burst_left    = 0;
    sent          = 0;
    settings      = 1;
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = mkdr_pkg::REG_REPEAT_DELAY;
    cfg_data      = '0;
    in_valid      = 1'b0;
    high_lines    = '1;
    low_lines     = '1;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // reset settings (delay 20, reload 18): directed corner cases first
    foreach (DIRECTED_SEQ[i]) send_tick(DIRECTED_SEQ[i][7:4], DIRECTED_SEQ[i][3:0]);
    gaps_on = 1'b1;
    random_runs(150);

    // delay 1, zero reload: repeat on every held tick
    reconfigure(8'd1, 8'd0);
    random_runs(90);

    // delay 0; sender pauses halfway until everything is back
    reconfigure(8'd0, 8'd0);
    random_runs(45);
    wait_drained();
    random_runs(45);

    // delay 0 with reload 255: hold counter wraps through zero
    reconfigure(8'd0, 8'd255);
    random_runs(90);

    // longest delay: one key held long enough to reach 255 and repeat
    reconfigure(8'd255, 8'd254);
    long_key = key_lines(mkdr_pkg::key_t'($urandom_range(0, 15)));
    repeat (2) send_tick(4'hF, 4'hF);
    repeat (270) send_tick(long_key[7:4], long_key[3:0]);
    random_runs(60);

    // reload above delay
    reconfigure(8'd3, 8'd255);
    random_runs(90);

    // back-to-back input while the receiver holds off for a long stretch
    reconfigure(8'd5, 8'd3);
    gaps_on       = 1'b0;
    stall_request = 1'b1;
    random_runs(90);
    gaps_on = 1'b1;

    reconfigure(8'd2, 8'd1);
    random_runs(90);

    reconfigure(mkdr_pkg::count_t'($urandom_range(1, 40)),
                mkdr_pkg::count_t'($urandom_range(0, 40)));
    random_runs(90);

    // drain, then let the pipeline sit so any stray word shows up
    wait_drained();
    repeat (8) @(posedge clk);
    if (tracker.pending() != 0) begin
      $error("%0d words never arrived", tracker.pending());
      tracker.fail_count++;
    end

    $display("Covered %0d line samples under %0d delay/reload settings.",
             tracker.words, settings);
    $display("Events seen: %0d presses, %0d auto-repeats, %0d undecodable patterns.",
             tracker.presses, tracker.repeats, tracker.undecodable);
    if (tracker.fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: matrix_keypad_debounce_repeat.f
rtl/core/mkdr_pkg.sv
rtl/core/matrix_keypad_debounce_repeat.sv
rtl/core/mkdr_checker.sv
verif/matrix_keypad_debounce_repeat_test.sv
